### hw/rtl/nearest_polygon_edge_finder_core_macros.svh
// ----------------------------------------------------------------------------
// nearest polygon edge finder assertion macros
// shared concurrent check forms
// ----------------------------------------------------------------------------
`ifndef NEAREST_POLYGON_EDGE_FINDER_CORE_MACROS_SVH
`define NEAREST_POLYGON_EDGE_FINDER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define NPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/npe_pkg.sv
// ----------------------------------------------------------------------------
// npe_pkg
// shared types and constants of the nearest polygon edge finder
// ----------------------------------------------------------------------------
package npe_pkg;

   localparam int CoordBits = 32;
   localparam int IdBits    = 16;
   localparam int PosBits   = 11;
   localparam int MaxVerts  = 1024;
   localparam int TFrac     = 32;
   localparam int ReqBits   = 4 * CoordBits + IdBits;
   localparam int RspBits   = IdBits + PosBits + 3 * CoordBits;
   localparam int ReqBytes  = (ReqBits + 7) / 8;
   localparam int RspBytes  = (RspBits + 7) / 8;

   localparam logic [31:0] DistMax = 32'hFFFF_FFFF;

   // datapath micro steps
   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_LOAD   = 4'd1,  // capture input beat, set edge prior->vertex
      OP_CLOSE  = 4'd2,  // set edge vertex->first
      OP_PREP   = 4'd3,  // deltas
      OP_MULA   = 4'd4,  // dot and len2 products
      OP_DIV    = 4'd5,  // one quotient bit
      OP_SCALE  = 4'd6,  // clamped t when the divider is not needed
      OP_PROJ   = 4'd7,  // projected point and offset
      OP_ESQ    = 4'd8,  // squared offset
      OP_SQRT   = 4'd9,  // one root bit
      OP_UPDATE = 4'd10, // running minimum
      OP_COMMIT = 4'd11, // per vertex state update
      OP_FLUSH  = 4'd12  // result out, clear polygon state
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic pos_zero;  // first vertex of the polygon
      logic last;      // current beat closes the polygon
      logic div_need;  // t needs the divider
   } status_type;

endpackage

### hw/rtl/npe_datapath.sv
// ----------------------------------------------------------------------------
// npe_datapath
// edge geometry, shared divider and root units, running minimum
// ----------------------------------------------------------------------------
module npe_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  npe_pkg::cmd_type                      cmd,
   input  logic [npe_pkg::ReqBits:0]             req_tdata,
   output npe_pkg::status_type                   status,
   output logic [npe_pkg::RspBytes*8-1:0]        rsp_data
);

   typedef logic signed [31:0] crd_type;

   // captured beat
   crd_type     qx_ff, qy_ff, vx_ff, vy_ff, qx_in, qy_in, vx_in, vy_in;
   logic [15:0] vid_ff, vid_in;
   logic        last_ff, last_in;
   // polygon state
   crd_type     fx_ff, fy_ff, px_ff, py_ff, fx_in, fy_in, px_in, py_in;
   logic [15:0] fid_ff, pid_ff, fid_in, pid_in;
   logic [10:0] pos_ff, pos_in;
   logic [31:0] bd_ff, bd_in;
   logic [15:0] bid_ff, bid_in;
   logic [10:0] bpos_ff, bpos_in;
   crd_type     bpx_ff, bpy_ff, bpx_in, bpy_in;
   // edge under work
   crd_type     ax_ff, ay_ff, ax_in, ay_in, bx_ff, by_ff, bx_in, by_in;
   logic [15:0] eid_ff, eid_in;
   logic [10:0] eins_ff, eins_in;
   logic signed [32:0] dx_ff, dy_ff, wx_ff, wy_ff, dx_in, dy_in, wx_in, wy_in;
   logic signed [66:0] dot_ff, dot_in;
   logic [66:0]        len_ff, len_in;
   logic [67:0]        rem_ff, rem_in;
   logic [32:0]        t_ff, t_in;
   crd_type     prx_ff, pry_ff, prx_in, pry_in;
   logic signed [33:0] ex_ff, ey_ff, ex_in, ey_in;
   logic [67:0] n_ff, n_in;
   logic [33:0] r_ff, r_in;
   logic [5:0]  bit_ff, bit_in;

   // combinational helpers
   logic [65:0] pmx, pmy, scx, scy;
   logic [67:0] trial, cand;
   logic [34:0] rc;
   logic [33:0] bitv;
   logic [32:0] mx, my;
   logic [31:0] dist_sat;
   logic signed [33:0] sxs, sys;

   always_comb begin
      mx  = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      my  = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      scx = 66'(t_ff) * 66'(mx) + (66'd1 << (npe_pkg::TFrac - 1));
      scy = 66'(t_ff) * 66'(my) + (66'd1 << (npe_pkg::TFrac - 1));
      sxs = dx_ff[32] ? -34'(scx[65:32]) : 34'(scx[65:32]);
      sys = dy_ff[32] ? -34'(scy[65:32]) : 34'(scy[65:32]);
      pmx = 66'(ex_ff[33] ? 34'(-ex_ff) : 34'(ex_ff));
      pmy = 66'(ey_ff[33] ? 34'(-ey_ff) : 34'(ey_ff));
      trial = {rem_ff[66:0], 1'b0};
      bitv  = 34'd1 << bit_ff;
      rc    = 35'(r_ff | bitv);
      cand  = 68'(70'(rc) * 70'(rc));
      dist_sat = (r_ff > 34'(npe_pkg::DistMax)) ? npe_pkg::DistMax : r_ff[31:0];
   end

   assign status.pos_zero = (pos_ff == '0);
   assign status.last     = last_ff;
   assign status.div_need = !(len_ff == '0 || dot_ff[66] || dot_ff == '0 ||
                              $unsigned(dot_ff) >= len_ff);

   always_comb begin
      {qx_in, qy_in, vx_in, vy_in, vid_in, last_in} =
         {qx_ff, qy_ff, vx_ff, vy_ff, vid_ff, last_ff};
      {fx_in, fy_in, fid_in, px_in, py_in, pid_in, pos_in} =
         {fx_ff, fy_ff, fid_ff, px_ff, py_ff, pid_ff, pos_ff};
      {bd_in, bid_in, bpos_in, bpx_in, bpy_in} = {bd_ff, bid_ff, bpos_ff, bpx_ff, bpy_ff};
      {ax_in, ay_in, bx_in, by_in, eid_in, eins_in} =
         {ax_ff, ay_ff, bx_ff, by_ff, eid_ff, eins_ff};
      {dx_in, dy_in, wx_in, wy_in} = {dx_ff, dy_ff, wx_ff, wy_ff};
      dot_in = dot_ff; len_in = len_ff; rem_in = rem_ff; t_in = t_ff;
      prx_in = prx_ff; pry_in = pry_ff;
      ex_in = ex_ff; ey_in = ey_ff; n_in = n_ff; r_in = r_ff; bit_in = bit_ff;
      case (cmd.op)
         npe_pkg::OP_LOAD: begin
            qx_in = req_tdata[31:0];   qy_in = req_tdata[63:32];
            vx_in = req_tdata[95:64];  vy_in = req_tdata[127:96];
            vid_in = req_tdata[143:128]; last_in = req_tdata[144];
            ax_in = px_ff; ay_in = py_ff; eid_in = pid_ff; eins_in = pos_ff;
            bx_in = req_tdata[95:64]; by_in = req_tdata[127:96];
            if (pos_ff == '0) begin
               fx_in = req_tdata[95:64]; fy_in = req_tdata[127:96];
               fid_in = req_tdata[143:128];
            end
         end
         npe_pkg::OP_CLOSE: begin
            ax_in = vx_ff; ay_in = vy_ff; bx_in = fx_ff; by_in = fy_ff;
            eid_in = vid_ff; eins_in = pos_ff + 11'd1;
         end
         npe_pkg::OP_PREP: begin
            dx_in = 33'(bx_ff) - 33'(ax_ff); dy_in = 33'(by_ff) - 33'(ay_ff);
            wx_in = 33'(qx_ff) - 33'(ax_ff); wy_in = 33'(qy_ff) - 33'(ay_ff);
         end
         npe_pkg::OP_MULA: begin
            dot_in = 67'(wx_ff * dx_ff) + 67'(wy_ff * dy_ff);
            len_in = 67'(66'(mx) * 66'(mx)) + 67'(66'(my) * 66'(my));
            rem_in = {1'b0, $unsigned(dot_in)};
            t_in = '0; bit_in = 6'd31;
         end
         npe_pkg::OP_DIV: begin
            if (trial >= {1'b0, len_ff}) begin
               rem_in = trial - {1'b0, len_ff};
               t_in = {t_ff[31:0], 1'b1};
            end else begin
               rem_in = trial;
               t_in = {t_ff[31:0], 1'b0};
            end
         end
         npe_pkg::OP_SCALE: begin
            if (!status.div_need)
               t_in = (len_ff != '0 && !dot_ff[66] && dot_ff != '0) ?
                      (33'd1 << npe_pkg::TFrac) : '0;
            else
               t_in = t_ff;
         end
         npe_pkg::OP_PROJ: begin
            prx_in = crd_type'(34'(ax_ff) + sxs);
            pry_in = crd_type'(34'(ay_ff) + sys);
            ex_in = 34'(qx_ff) - 34'(prx_in);
            ey_in = 34'(qy_ff) - 34'(pry_in);
         end
         npe_pkg::OP_ESQ: begin
            n_in = 68'(pmx * pmx) + 68'(pmy * pmy);
            r_in = '0; bit_in = 6'd33;
         end
         npe_pkg::OP_SQRT: begin
            if (cand <= n_ff) r_in = r_ff | bitv;
            bit_in = bit_ff - 6'd1;
         end
         npe_pkg::OP_UPDATE: begin
            if (dist_sat < bd_ff) begin
               bd_in = dist_sat; bid_in = eid_ff; bpos_in = eins_ff;
               bpx_in = prx_ff; bpy_in = pry_ff;
            end
         end
         npe_pkg::OP_COMMIT: begin
            px_in = vx_ff; py_in = vy_ff; pid_in = vid_ff;
            if (pos_ff != 11'(npe_pkg::MaxVerts - 1)) pos_in = pos_ff + 11'd1;
         end
         npe_pkg::OP_FLUSH: begin
            {fx_in, fy_in, fid_in, px_in, py_in, pid_in, pos_in} = '0;
            bd_in = npe_pkg::DistMax; bid_in = '0; bpos_in = '0;
            bpx_in = '0; bpy_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = {{(npe_pkg::RspBytes*8-npe_pkg::RspBits){1'b0}},
                      bpy_ff, bpx_ff, bd_ff, bpos_ff, bid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         {fx_ff, fy_ff, fid_ff, px_ff, py_ff, pid_ff, pos_ff} <= '0;
         bd_ff <= npe_pkg::DistMax; bid_ff <= '0; bpos_ff <= '0;
         bpx_ff <= '0; bpy_ff <= '0; last_ff <= 1'b0;
      end else begin
         {fx_ff, fy_ff, fid_ff, px_ff, py_ff, pid_ff, pos_ff} <=
            {fx_in, fy_in, fid_in, px_in, py_in, pid_in, pos_in};
         {bd_ff, bid_ff, bpos_ff, bpx_ff, bpy_ff} <= {bd_in, bid_in, bpos_in, bpx_in, bpy_in};
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      {qx_ff, qy_ff, vx_ff, vy_ff, vid_ff} <= {qx_in, qy_in, vx_in, vy_in, vid_in};
      {ax_ff, ay_ff, bx_ff, by_ff, eid_ff, eins_ff} <=
         {ax_in, ay_in, bx_in, by_in, eid_in, eins_in};
      {dx_ff, dy_ff, wx_ff, wy_ff} <= {dx_in, dy_in, wx_in, wy_in};
      dot_ff <= dot_in; len_ff <= len_in; rem_ff <= rem_in; t_ff <= t_in;
      prx_ff <= prx_in; pry_ff <= pry_in;
      ex_ff <= ex_in; ey_ff <= ey_in; n_ff <= n_in; r_ff <= r_in; bit_ff <= bit_in;
   end

endmodule

### hw/rtl/npe_controller.sv
// ----------------------------------------------------------------------------
// npe_controller
// sequences a vertex beat through its edge measurements: the opening edge, the closing edge, neither or both
// ----------------------------------------------------------------------------
module npe_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  npe_pkg::status_type status,
   output npe_pkg::cmd_type    cmd,
   output logic                rsp_load
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_CLOSE  = 13'b0000000000010,
      ST_PREP   = 13'b0000000000100,
      ST_MULA   = 13'b0000000001000,
      ST_DIV    = 13'b0000000010000,
      ST_SCALE  = 13'b0000000100000,
      ST_PROJ   = 13'b0000001000000,
      ST_ESQ    = 13'b0000010000000,
      ST_SQRT   = 13'b0000100000000,
      ST_UPDATE = 13'b0001000000000,
      ST_NEXT   = 13'b0010000000000,
      ST_COMMIT = 13'b0100000000000,
      ST_FLUSH  = 13'b1000000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        closing_ff, closing_in;
   logic        rv_ff, rv_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rv_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; closing_in = closing_ff;
      rv_in = rv_ff && !rsp_tready;
      cmd.op = npe_pkg::OP_NONE;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op = npe_pkg::OP_LOAD;
               closing_in = 1'b0;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // first vertex has no opening edge
            if (!closing_ff && !status.pos_zero) state_in = ST_PREP;
            else if (!closing_ff && status.last) state_in = ST_CLOSE;
            else if (closing_ff) state_in = ST_FLUSH;
            else state_in = ST_COMMIT;
         end
         ST_CLOSE: begin
            cmd.op = npe_pkg::OP_CLOSE;
            closing_in = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin cmd.op = npe_pkg::OP_PREP; state_in = ST_MULA; end
         ST_MULA: begin
            cmd.op = npe_pkg::OP_MULA; cnt_in = 6'd31; state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_need) state_in = ST_SCALE;
            else begin
               cmd.op = npe_pkg::OP_DIV;
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == '0) state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin cmd.op = npe_pkg::OP_SCALE; state_in = ST_PROJ; end
         ST_PROJ:  begin cmd.op = npe_pkg::OP_PROJ;  state_in = ST_ESQ; end
         ST_ESQ: begin
            cmd.op = npe_pkg::OP_ESQ; cnt_in = 6'd33; state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = npe_pkg::OP_SQRT;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op = npe_pkg::OP_UPDATE;
            if (closing_ff) state_in = ST_FLUSH;
            else if (status.last) state_in = ST_CLOSE;
            else state_in = ST_COMMIT;
         end
         ST_COMMIT: begin cmd.op = npe_pkg::OP_COMMIT; state_in = ST_IDLE; end
         ST_FLUSH: begin
            // wait for the output register to free
            if (!rv_ff || rsp_tready) begin
               rsp_load = 1'b1;
               rv_in = 1'b1;
               cmd.op = npe_pkg::OP_FLUSH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rv_ff <= 1'b0; closing_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; closing_ff <= closing_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### hw/rtl/nearest_polygon_edge_finder_core.sv
// ----------------------------------------------------------------------------
// nearest_polygon_edge_finder_core
// nearest edge of a streamed closed polygon to a query point
// ----------------------------------------------------------------------------
// channel  dir  beat payload
// req_     in   query x/y, vertex x/y, vertex id; tlast = last vertex
// rsp_     out  start id, insert position, distance, projected x/y
//
// each edge runs the bit-serial divider
//   (32 steps, skipped when t clamps) and the bit-serial root (34 steps)
// a vertex beat measures its opening edge, the first vertex has none;
//   the last beat adds the closing edge, which is all a lone vertex measures
// reset: synchronous, clears polygon state and the running minimum
// stalls: a held result only stalls the flush of the next polygon
// ----------------------------------------------------------------------------
`include "nearest_polygon_edge_finder_core_macros.svh"

module nearest_polygon_edge_finder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // query_x, query_y, vertex_x, vertex_y, vertex ident
   input  logic [npe_pkg::ReqBytes*8-1:0]     req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // nearest_start_id, insert_position, nearest_distance,
   // nearest_proj_x, nearest_proj_y, zero fill
   output logic [npe_pkg::RspBytes*8-1:0]     rsp_tdata
);

   npe_pkg::cmd_type    cmd;
   npe_pkg::status_type status;
   logic                rsp_load;
   logic [npe_pkg::RspBytes*8-1:0] result;
   logic [npe_pkg::RspBytes*8-1:0] rsp_ff;
   logic [npe_pkg::ReqBits:0]      beat;

   // tlast rides one bit above the id field
   assign beat = {req_tlast, req_tdata[npe_pkg::ReqBits-1:0]};

   npe_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .rsp_load   (rsp_load)
   );

   npe_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (beat),
      .status    (status),
      .rsp_data  (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= result;
   end
   assign rsp_tdata = rsp_ff;

   `NPE_ASSERT_NEXT(a_load_busy, clock, reset, req_tvalid && req_tready, !req_tready, "accept did not leave idle")
   `NPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `NPE_ASSERT_IMP(a_load_free, clock, reset, rsp_load, !rsp_tvalid || rsp_tready, "result overwritten")

endmodule

### test/nearest_polygon_edge_finder_core_tb.sv
// ----------------------------------------------------------------------------
// nearest_polygon_edge_finder_core_tb
// streams closed polygons with a query point into the core and checks the
// nearest edge, insert position, distance and projected point of each polygon
// against a bit-exact predictor, with and without random sender/receiver gaps
// ----------------------------------------------------------------------------
module nearest_polygon_edge_finder_core_tb;

   localparam int ReqW       = npe_pkg::ReqBytes * 8;
   localparam int RspW       = npe_pkg::RspBytes * 8;
   localparam int StallLimit = 20000;

   // fields from the highest bit down
   typedef struct packed {
      logic [31:0] proj_y;
      logic [31:0] proj_x;
      logic [31:0] distance;
      logic [10:0] ins_pos;
      logic [15:0] start_id;
   } edge_hit_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [ReqW-1:0] req_tdata = '0;
   logic            req_tlast = 1'b0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [RspW-1:0] rsp_tdata;

   // polygon state of the predictor
   logic signed [63:0] first_x, first_y, prev_x, prev_y;
   logic [15:0]        first_id, prev_id;
   int unsigned        vert_pos;
   logic [63:0]        best_dist;
   logic [15:0]        best_id;
   logic [10:0]        best_pos;
   logic signed [63:0] best_px, best_py;

   edge_hit_type hits_due[$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int unsigned send_gap_pct = 0;
   int unsigned recv_gap_pct = 0;
   bit          timed_out = 1'b0;

   nearest_polygon_edge_finder_core u_dut (.*);

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   function automatic void clear_polygon();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      first_id = 0; prev_id = 0; vert_pos = 0;
      best_dist = 64'hFFFF_FFFF; best_id = 0; best_pos = 0;
      best_px = 0; best_py = 0;
   endfunction

   function automatic logic [63:0] isqrt(input logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  c;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   // t*d / 2^32, rounded half away from zero
   function automatic logic signed [63:0] scaled(input logic [63:0] t,
                                                 input logic signed [63:0] d);
      logic [63:0]  m;
      logic [127:0] p;
      m = d < 0 ? -d : d;
      p = ({64'd0, t} * {64'd0, m}) + (128'd1 << 31);
      p = p >> 32;
      return d < 0 ? -$signed(p[63:0]) : $signed(p[63:0]);
   endfunction

   function automatic void measure_edge(input logic signed [63:0] qx, qy, ax, ay,
                                        bx, by, input logic [15:0] sid,
                                        input int unsigned ins);
      logic signed [63:0]  dx, dy, px, py, ex, ey;
      logic signed [127:0] dot, len2;
      logic [63:0]         t, d;
      dx = bx - ax; dy = by - ay;
      len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      dot  = 128'(qx - ax) * 128'(dx) + 128'(qy - ay) * 128'(dy);
      if (len2 == 0 || dot <= 0) t = 0;
      else if (dot >= len2) t = 64'd1 << 32;
      else t = 64'((dot <<< 32) / len2);
      px = ax + scaled(t, dx);
      py = ay + scaled(t, dy);
      ex = qx - px; ey = qy - py;
      d = isqrt(128'(ex * ex) + 128'(ey * ey));
      if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
      if (d < best_dist) begin
         best_dist = d; best_id = sid; best_pos = 11'(ins);
         best_px = px; best_py = py;
      end
   endfunction

   function automatic void predict_vertex(input logic signed [31:0] qx, qy, vx, vy,
                                          input logic [15:0] vid, input bit last);
      edge_hit_type h;
      if (vert_pos == 0) begin
         first_x = vx; first_y = vy; first_id = vid;
      end else begin
         measure_edge(qx, qy, prev_x, prev_y, vx, vy, prev_id, vert_pos);
      end
      if (last) begin
         measure_edge(qx, qy, vx, vy, first_x, first_y, vid, vert_pos + 1);
         h.start_id = best_id; h.ins_pos = best_pos; h.distance = best_dist[31:0];
         h.proj_x = best_px[31:0]; h.proj_y = best_py[31:0];
         hits_due = {hits_due, h};
         clear_polygon();
         return;
      end
      prev_x = vx; prev_y = vy; prev_id = vid;
      vert_pos = (vert_pos + 1 < npe_pkg::MaxVerts) ? vert_pos + 1 : npe_pkg::MaxVerts - 1;
   endfunction

   // one vertex beat; prediction made at acceptance
   task automatic send_vertex(input logic [31:0] qx, qy, vx, vy,
                              input logic [15:0] vid, input bit last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqW'({vid, vy, vx, qy, qx});
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_vertex(qx, qy, vx, vy, vid, last);
   endtask

   function automatic logic [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed(32'($urandom_range(4000))) - 2000);
         default: return 32'($signed(32'($urandom_range(400000))) - 200000);
      endcase
   endfunction

   // receiver, checker and watchdog
   always @(posedge clock) begin
      edge_hit_type got;
      edge_hit_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = edge_hit_type'(rsp_tdata[npe_pkg::RspBits-1:0]);
            if (hits_due.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[63:0], 0);
            end else begin
               want = hits_due.pop_front();
               if (got.start_id != want.start_id)
                  report_mismatch("start id", got.start_id, want.start_id);
               if (got.ins_pos != want.ins_pos)
                  report_mismatch("insert position", got.ins_pos, want.ins_pos);
               if (got.distance != want.distance)
                  report_mismatch("distance", got.distance, want.distance);
               if (got.proj_x != want.proj_x)
                  report_mismatch("proj x", got.proj_x, want.proj_x);
               if (got.proj_y != want.proj_y)
                  report_mismatch("proj y", got.proj_y, want.proj_y);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("[nearest_polygon_edge_finder_core] ERROR");
            $finish;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
   end

   task automatic test_extremes();
      logic [31:0] ext [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
      // single vertex polygon: closing edge to itself
      send_vertex(32'd100, 32'd50, 32'd0, 32'd0, 16'hFFFF, 1'b1);
      // extreme corners, saturating distance
      send_vertex(ext[0], ext[0], ext[1], ext[1], 16'h0001, 1'b0);
      send_vertex(ext[0], ext[0], ext[1], ext[1], 16'h0002, 1'b0);
      send_vertex(ext[0], ext[0], ext[1], ext[0] + 1, 16'h0003, 1'b1);
      // zero-length edges and a far corner query
      send_vertex(ext[1], ext[0], ext[0], ext[1], 16'hAAAA, 1'b0);
      send_vertex(ext[1], ext[0], ext[0], ext[1], 16'h5555, 1'b1);
      // square with the query outside, a query on a vertex, and clamping both ends
      for (int k = 0; k < 4; k++) begin
         send_vertex(ext[2], 32'd300, 32'h100 * (k == 1 || k == 2),
                     32'h100 * (k >= 2), 16'(k), 1'b0);
      end
      send_vertex(32'hFFFF_F000, 32'd128, 32'd0, 32'd0, 16'd9, 1'b1);
      send_vertex(32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0);
      send_vertex(32'd0, 32'd0, 32'd1000, 32'hFFFF_FC18, 16'd1, 1'b1);
      send_vertex(ext[3], ext[3], 32'd7, 32'd7, 16'd7, 1'b0);
      send_vertex(ext[3], ext[3], 32'd7, 32'd7, 16'd7, 1'b1);
   endtask

   task automatic test_random_polygons(input int n_items);
      int sent = 0;
      int len, mode;
      logic [31:0] qx, qy;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
         mode = $urandom_range(5) == 0 ? 0 : $urandom_range(2, 1);
         qx = rand_coord(mode); qy = rand_coord(mode);
         for (int k = 0; k < len; k++) begin
            // query usually fixed per polygon, sometimes moving
            if ($urandom_range(7) == 0) begin
               qx = rand_coord(mode); qy = rand_coord(mode);
            end
            send_vertex(qx, qy, rand_coord(mode), rand_coord(mode),
                        16'($urandom()), k == len - 1);
         end
         sent += len;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      clear_polygon();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_gap_pct = 8; recv_gap_pct = 84;
      test_extremes();
      test_random_polygons(275);
      send_gap_pct = 84; recv_gap_pct = 8;
      test_random_polygons(275);
      send_gap_pct = 0; recv_gap_pct = 0;
      test_random_polygons(275);
      drain();
      if (fail_count == 0 && hits_due.size() == 0)
         $display("[nearest_polygon_edge_finder_core] OK");
      else
         $display("[nearest_polygon_edge_finder_core] ERROR");
      $finish;
   end

endmodule
